// ----- src/swcs_pkg.sv -----
// ----------------------------------------------------------------------------
// swcs_pkg: shared types and constants for the congestion window sender
// Event codes, configuration register indexes, result record and the
// slow-start window growth function.
// ----------------------------------------------------------------------------
package swcs_pkg;

  localparam int ID_BITS_DEF = 16;
  localparam int DATA_W      = 16;
  localparam int CFG_ADDR_W  = 1;

  localparam logic [7:0]  DUP_LIMIT   = 8'd3;
  localparam logic [7:0]  DUP_MAX     = 8'hFF;
  localparam logic [15:0] WIN_RESET   = 16'h1000;
  localparam logic [15:0] WIN_MAX     = 16'hFF00;
  localparam logic [7:0]  LIMIT_RESET = 8'd130;
  localparam logic [15:0] TOTAL_RESET = 16'd0;

  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SLOW_START_LIMIT = 1'b0,
    CFG_TOTAL_PACKETS    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] packet_id;
    logic        is_retransmit;
    logic        all_acked;
  } result_t;

  // window growth in unsigned 8.8, saturating at 255.0
  function automatic logic [15:0] grow_window(input logic [15:0] w, input logic [7:0] limit);
    logic [16:0] lim;
    logic [16:0] dbl;
    logic [16:0] inc;
    logic [16:0] nw;
    lim = {1'b0, limit, 8'h00};
    dbl = {w, 1'b0};
    inc = {1'b0, w} + 17'd256;
    if (dbl <= lim) begin
      nw = dbl;
    end else if ({1'b0, w} < lim) begin
      nw = lim;
    end else begin
      nw = inc;
    end
    return (nw > {1'b0, WIN_MAX}) ? WIN_MAX : nw[15:0];
  endfunction

endpackage

// ----- src/swcs_engine.sv -----
// ----------------------------------------------------------------------------
// swcs_engine: window state and per-event update
// Holds the sender state and configuration, computes the result of one
// event combinationally and commits the new state when the event fires.
// ----------------------------------------------------------------------------
module swcs_engine #(
  parameter int ID_BITS = swcs_pkg::ID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  swcs_pkg::cfg_reg_t                  cfg_addr,
  input  logic [swcs_pkg::DATA_W-1:0]         cfg_wdata,
  input  logic                                fire,
  input  swcs_pkg::action_t                   action,
  input  logic [swcs_pkg::DATA_W-1:0]         ack_id,
  output logic                                res_valid,
  output swcs_pkg::result_t                   res,
  output logic [ID_BITS:0]                    next_id,
  output logic [ID_BITS:0]                    oldest_id,
  output logic [15:0]                         window
);

  localparam int CW = ID_BITS + 1;
  localparam int AB = (ID_BITS < swcs_pkg::DATA_W) ? ID_BITS : swcs_pkg::DATA_W;
  localparam int WW = (CW > swcs_pkg::DATA_W) ? CW : swcs_pkg::DATA_W;

  logic [7:0]    limit_r;
  logic [15:0]   total_r;
  logic [CW-1:0] next_id_r, next_id_nxt;
  logic [CW-1:0] oldest_r, oldest_nxt;
  logic [15:0]   win_r, win_nxt;
  logic [CW-1:0] base_r, base_nxt;
  logic [AB-1:0] prev_r, prev_nxt;
  logic [7:0]    dup_r, dup_nxt;
  logic          fin_r, fin_nxt;

  logic [WW-1:0] tp_w;
  logic [WW-1:0] id_mask_w;
  logic [CW-1:0] total_c;
  logic [CW-1:0] ack_c;
  logic [CW-1:0] inflight;
  logic [7:0]    dup_inc;
  logic [CW:0]   pos1;
  logic          closes;
  logic [CW:0]   base_sum;
  logic [CW-1:0] base_grow;
  logic          retx_dup;
  logic [CW-1:0] oldest_upd;
  logic [CW-1:0] res_id;
  logic          res_retx;
  logic [WW-1:0] res_id_w;

  assign tp_w      = WW'(total_r);
  assign id_mask_w = WW'({ID_BITS{1'b1}});
  assign total_c   = (tp_w > id_mask_w) ? CW'(id_mask_w) : CW'(tp_w);
  assign ack_c     = CW'(ack_id[AB-1:0]);
  assign inflight  = next_id_r - oldest_r;
  assign dup_inc   = (dup_r == swcs_pkg::DUP_MAX) ? dup_r : dup_r + 8'd1;
  assign pos1      = {1'b0, ack_c - base_r} + (CW+1)'(1);
  assign closes    = (ack_c >= base_r) && (win_r[7:0] == 8'h00) &&
                     (pos1 == (CW+1)'(win_r[15:8]));
  assign base_sum  = {1'b0, base_r} + (CW+1)'(win_r[15:8]);
  assign base_grow = base_sum[CW] ? {CW{1'b1}} : base_sum[CW-1:0];

  always_comb begin
    next_id_nxt = next_id_r;
    oldest_nxt  = oldest_r;
    win_nxt     = win_r;
    base_nxt    = base_r;
    prev_nxt    = prev_r;
    dup_nxt     = dup_r;
    fin_nxt     = fin_r;
    res_valid   = 1'b0;
    res_id      = oldest_r;
    res_retx    = 1'b0;
    retx_dup    = 1'b0;
    oldest_upd  = oldest_r;
    unique case (action)
      swcs_pkg::ACT_SEND: begin
        if ((next_id_r <= total_c) && (inflight < CW'(win_r[15:8]))) begin
          res_valid   = 1'b1;
          res_id      = next_id_r;
          next_id_nxt = next_id_r + CW'(1);
        end
      end
      swcs_pkg::ACT_ACK: begin
        if (ack_c[AB-1:0] == prev_r) begin
          dup_nxt = dup_inc;
          if (dup_inc == swcs_pkg::DUP_LIMIT) begin
            retx_dup = 1'b1;
          end
        end else begin
          prev_nxt = ack_c[AB-1:0];
          dup_nxt  = 8'd1;
        end
        if (retx_dup) begin
          base_nxt = oldest_r;
          if (oldest_r < next_id_r) begin
            res_valid = 1'b1;
            res_retx  = 1'b1;
          end
        end else begin
          if ((ack_c == oldest_r) && (ack_c < next_id_r)) begin
            oldest_upd = oldest_r + CW'(1);
            if (closes) begin
              base_nxt = base_grow;
              win_nxt  = swcs_pkg::grow_window(win_r, limit_r);
            end
          end else if ((ack_c > oldest_r) && (ack_c < next_id_r)) begin
            oldest_upd = ack_c + CW'(1);
          end
          oldest_nxt = oldest_upd;
          if (oldest_upd > total_c) begin
            fin_nxt = 1'b1;
          end
        end
      end
      swcs_pkg::ACT_TIMEOUT: begin
        win_nxt  = {1'b0, win_r[15:1]};
        base_nxt = oldest_r;
        if (oldest_r < next_id_r) begin
          res_valid = 1'b1;
          res_retx  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_id_w          = WW'(res_id);
  assign res.packet_id     = res_id_w[15:0];
  assign res.is_retransmit = res_retx;
  assign res.all_acked     = fin_r;

  assign next_id   = next_id_r;
  assign oldest_id = oldest_r;
  assign window    = win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= swcs_pkg::LIMIT_RESET;
      total_r   <= swcs_pkg::TOTAL_RESET;
      next_id_r <= CW'(1);
      oldest_r  <= CW'(1);
      win_r     <= swcs_pkg::WIN_RESET;
      base_r    <= CW'(1);
      prev_r    <= '0;
      dup_r     <= 8'd0;
      fin_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          swcs_pkg::CFG_SLOW_START_LIMIT: limit_r <= cfg_wdata[7:0];
          swcs_pkg::CFG_TOTAL_PACKETS:    total_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (fire) begin
        next_id_r <= next_id_nxt;
        oldest_r  <= oldest_nxt;
        win_r     <= win_nxt;
        base_r    <= base_nxt;
        prev_r    <= prev_nxt;
        dup_r     <= dup_nxt;
        fin_r     <= fin_nxt;
      end
    end
  end

endmodule

// ----- src/sliding_window_congestion_sender.sv -----
// ----------------------------------------------------------------------------
// sliding_window_congestion_sender: packet sender with slow-start window
// Events arrive on the in_ stream: tuser is the event kind (send slot,
// acknowledgement, timeout), tdata the acknowledged id. Each event yields
// zero or one transaction on the out_ stream: the id to transmit, a
// retransmit flag in tuser and the all-acked status in tdata.
// An accepted event is held in the input register, is evaluated and its
// result, if any, lands in the output register that drives out_tvalid.
// One event per cycle is sustained while out_tready stays high.
// When out_tready is low with a result pending, the event in the input
// register waits and in_tready drops; nothing is lost or reordered.
// Configuration (cfg_addr 0 slow start limit, 1 total packets) is written with
// cfg_we; the user must keep the stream idle then; the block does not enforce it.
// Synchronous reset clears both stages and restores the window to 16.0,
// all ids to one and the configuration to its defaults.
// ----------------------------------------------------------------------------
module sliding_window_congestion_sender #(
  parameter int ID_BITS = swcs_pkg::ID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [swcs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [swcs_pkg::DATA_W-1:0]         cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [15:0]                         in_tdata,   // ack_id
  input  logic [1:0]                          in_tuser,   // action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,  // packet_id, all_acked, zero fill
  output logic                                out_tuser   // is_retransmit
);

  logic              in_valid_r;
  swcs_pkg::action_t in_act_r;
  logic [15:0]       in_ack_r;
  logic              out_valid_r;
  swcs_pkg::result_t out_res_r;

  logic              fire;
  logic              res_valid;
  swcs_pkg::result_t res;
  logic [ID_BITS:0]  next_id;
  logic [ID_BITS:0]  oldest_id;
  logic [15:0]       window;

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  swcs_engine #(
    .ID_BITS (ID_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (swcs_pkg::cfg_reg_t'(cfg_addr)),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .action    (in_act_r),
    .ack_id    (in_ack_r),
    .res_valid (res_valid),
    .res       (res),
    .next_id   (next_id),
    .oldest_id (oldest_id),
    .window    (window)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (fire) begin
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_act_r <= swcs_pkg::action_t'(in_tuser);
      in_ack_r <= in_tdata;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.all_acked, out_res_r.packet_id};
  assign out_tuser  = out_res_r.is_retransmit;

  // oldest unacked id never passes the next new id
  assert property (@(posedge clk) disable iff (!rst_n) oldest_id <= next_id)
    else $error("oldest unacked id beyond next new id");

  // window stays within the saturation bound
  assert property (@(posedge clk) disable iff (!rst_n) window <= swcs_pkg::WIN_MAX)
    else $error("window above saturation limit");

  // an empty output register never blocks the input side
  assert property (@(posedge clk) disable iff (!rst_n) !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  // a result produced by a firing event reaches the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid) |=> out_valid_r)
    else $error("result lost between engine and output register");

endmodule

// ----- test/tb_sliding_window_congestion_sender.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_congestion_sender: self-checking bench for the sender
// Drives send slots, acknowledgements and timeouts on the event stream and
// checks every transmit transaction (packet id, resend flag, all-acked flag)
// against an in-bench model of the window and id counters. A short directed
// opening covers empty transfers, duplicate, old, unsent and cumulative acks
// and timeouts; random phases then run well-formed transfers under several
// slow-start limits and packet totals with varying backpressure on both
// streams, ending with the window halved down to nothing.
// ----------------------------------------------------------------------------
module tb_sliding_window_congestion_sender;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         SETTLE_TICKS = 6;
  localparam int         NUM_PHASES   = 8;

  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] ack_id;
  } sender_event_t;

  typedef struct {
    logic [16:0] next_id;
    logic [16:0] oldest_id;
    logic [16:0] base_id;
    logic [15:0] cwnd;
    logic [15:0] prev_ack_id;
    logic [7:0]  dup_cnt;
    logic        all_done;
  } sender_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [swcs_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [swcs_pkg::DATA_W-1:0]     cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // ack_id
  logic [1:0]  in_tuser = '0;   // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // packet_id, all_acked, zero fill
  logic        out_tuser;       // is_retransmit

  logic [7:0]  ss_limit = swcs_pkg::LIMIT_RESET;
  logic [15:0] total_pkts = swcs_pkg::TOTAL_RESET;
  sender_state_t gen_st;
  sender_state_t chk_st;

  sender_event_t     event_q[$];
  swcs_pkg::result_t tx_q[$];

  int send_gap_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int events_taken = 0;
  int tx_seen = 0;
  int resends_seen = 0;
  int cycles = 0;

  sliding_window_congestion_sender u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic sender_state_t reset_state();
    sender_state_t s;
    s.next_id     = 17'd1;
    s.oldest_id   = 17'd1;
    s.base_id     = 17'd1;
    s.cwnd        = swcs_pkg::WIN_RESET;
    s.prev_ack_id = 16'd0;
    s.dup_cnt     = 8'd0;
    s.all_done    = 1'b0;
    return s;
  endfunction

  // slow start: double, jump to the limit, or add one; 8.8 saturating at 255.0
  function automatic logic [15:0] next_cwnd(input logic [15:0] w);
    int unsigned cap;
    int unsigned wv;
    int unsigned grown;
    cap = {ss_limit, 8'h00};
    wv  = w;
    if (2 * wv <= cap) begin
      grown = 2 * wv;
    end else if (wv < cap) begin
      grown = cap;
    end else begin
      grown = wv + 256;
    end
    return (grown > swcs_pkg::WIN_MAX) ? swcs_pkg::WIN_MAX : grown[15:0];
  endfunction

  // applies one event, returns 1 when a packet goes out
  function automatic bit transmit_decision(inout sender_state_t s, input sender_event_t ev,
                                           output swcs_pkg::result_t r);
    logic [16:0] ack;
    logic [16:0] inflight;
    int unsigned span;
    int unsigned nb;
    ack = {1'b0, ev.ack_id};
    r = '0;
    case (ev.act)
      swcs_pkg::ACT_SEND: begin
        inflight = s.next_id - s.oldest_id;
        if (s.next_id <= total_pkts && inflight < s.cwnd[15:8]) begin
          r.packet_id = s.next_id[15:0];
          r.all_acked = s.all_done;
          s.next_id = s.next_id + 17'd1;
          return 1'b1;
        end
      end
      swcs_pkg::ACT_ACK: begin
        if (ev.ack_id == s.prev_ack_id) begin
          if (s.dup_cnt != swcs_pkg::DUP_MAX) begin
            s.dup_cnt = s.dup_cnt + 8'd1;
          end
          if (s.dup_cnt == swcs_pkg::DUP_LIMIT) begin
            s.base_id = s.oldest_id;
            if (s.oldest_id < s.next_id) begin
              r.packet_id = s.oldest_id[15:0];
              r.is_retransmit = 1'b1;
              r.all_acked = s.all_done;
              return 1'b1;
            end
            return 1'b0;
          end
        end else begin
          s.prev_ack_id = ev.ack_id;
          s.dup_cnt = 8'd1;
        end
        if (ack == s.oldest_id && ack < s.next_id) begin
          s.oldest_id = s.oldest_id + 17'd1;
          if (ack >= s.base_id) begin
            span = ack - s.base_id;
            if (((span + 1) << 8) == s.cwnd) begin
              nb = s.base_id + s.cwnd[15:8];
              s.base_id = (nb > 17'h1FFFF) ? 17'h1FFFF : nb[16:0];
              s.cwnd = next_cwnd(s.cwnd);
            end
          end
        end else if (ack > s.oldest_id && ack < s.next_id) begin
          s.oldest_id = ack + 17'd1;
        end
        if (s.oldest_id > total_pkts) begin
          s.all_done = 1'b1;
        end
      end
      swcs_pkg::ACT_TIMEOUT: begin
        s.cwnd = s.cwnd >> 1;
        s.base_id = s.oldest_id;
        if (s.oldest_id < s.next_id) begin
          r.packet_id = s.oldest_id[15:0];
          r.is_retransmit = 1'b1;
          r.all_acked = s.all_done;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic sender_event_t make_event(input logic [1:0] act, input logic [15:0] id);
    sender_event_t ev;
    ev.act = act;
    ev.ack_id = id;
    return ev;
  endfunction

  task automatic queue_event(input sender_event_t ev);
    swcs_pkg::result_t scratch;
    void'(transmit_decision(gen_st, ev, scratch));
    event_q = {event_q, ev};
  endtask

  task automatic write_reg(input swcs_pkg::cfg_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      swcs_pkg::CFG_SLOW_START_LIMIT: ss_limit = val[7:0];
      swcs_pkg::CFG_TOTAL_PACKETS:    total_pkts = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (event_q.size() != 0 || in_tvalid || tx_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_TICKS) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin
        send_gap_pct = 75;
        stall_pct = 0;
      end
      2: begin
        send_gap_pct = 0;
        stall_pct = 75;
      end
      3: begin
        send_gap_pct = 6;
        stall_pct = 6;
      end
      default: begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  // mostly well-formed transfers: in-order sends and acks, with some
  // cumulative, duplicate, stale and unsent acks and occasional timeouts
  task automatic fill_random(input int n);
    logic [16:0] inflight;
    bit          can_send;
    int          roll;
    int          sub;
    logic [15:0] id;
    for (int k = 0; k < n; k++) begin
      inflight = gen_st.next_id - gen_st.oldest_id;
      can_send = gen_st.next_id <= total_pkts && inflight < gen_st.cwnd[15:8];
      roll = $urandom_range(99);
      sub = $urandom_range(99);
      if (roll < 3) begin
        queue_event(make_event(2'($urandom_range(3)), 16'($urandom)));
      end else if (roll < 7 && gen_st.cwnd >= 16'h0800) begin
        queue_event(make_event(swcs_pkg::ACT_TIMEOUT, 16'($urandom)));
      end else if (can_send && roll < 55) begin
        queue_event(make_event(swcs_pkg::ACT_SEND, 16'($urandom)));
      end else if (gen_st.oldest_id < gen_st.next_id) begin
        if (sub < 65) begin
          id = gen_st.oldest_id[15:0];
        end else if (sub < 77) begin
          id = 16'(gen_st.oldest_id +
                   $urandom_range(gen_st.next_id - gen_st.oldest_id - 1));
        end else if (sub < 87) begin
          id = gen_st.prev_ack_id;
          queue_event(make_event(swcs_pkg::ACT_ACK, id));
        end else if (sub < 93) begin
          id = (gen_st.oldest_id > 17'd1) ? 16'($urandom_range(gen_st.oldest_id - 1)) : 16'd0;
        end else if (gen_st.next_id <= 17'hFFFF) begin
          id = 16'($urandom_range(65535, gen_st.next_id));
        end else begin
          id = 16'($urandom);
        end
        queue_event(make_event(swcs_pkg::ACT_ACK, id));
      end else if (sub < 50) begin
        queue_event(make_event(swcs_pkg::ACT_ACK, gen_st.prev_ack_id));
        queue_event(make_event(swcs_pkg::ACT_ACK, gen_st.prev_ack_id));
      end else begin
        queue_event(make_event(swcs_pkg::ACT_ACK, 16'($urandom)));
      end
    end
  endtask

  // event driver: holds the transaction until accepted
  always @(posedge clk) begin : drive_events
    sender_event_t     ev;
    swcs_pkg::result_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        events_taken++;
        if (transmit_decision(chk_st, make_event(in_tuser, in_tdata), r)) begin
          tx_q = {tx_q, r};
        end
      end
      if (!in_tvalid || in_tready) begin
        if (event_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          ev = event_q[0];
          event_q.delete(0);
          in_tvalid <= 1'b1;
          in_tdata <= ev.ack_id;
          in_tuser <= ev.act;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // transmit monitor
  always @(posedge clk) begin : watch_tx
    swcs_pkg::result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        tx_seen++;
        if (out_tuser) begin
          resends_seen++;
        end
        if (tx_q.size() == 0) begin
          $error("unexpected transaction: packet_id %0d", out_tdata[15:0]);
          mismatches++;
        end else begin
          want = tx_q[0];
          tx_q.delete(0);
          if (out_tdata[15:0] !== want.packet_id) begin
            $error("packet_id expected %0d, actual %0d", want.packet_id, out_tdata[15:0]);
            mismatches++;
          end
          if (out_tuser !== want.is_retransmit) begin
            $error("is_retransmit expected %0b, actual %0b", want.is_retransmit, out_tuser);
            mismatches++;
          end
          if (out_tdata[16] !== want.all_acked) begin
            $error("all_acked expected %0b, actual %0b", want.all_acked, out_tdata[16]);
            mismatches++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0]  lim;
    int unsigned tot;
    gen_st = reset_state();
    chk_st = reset_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty transfer: nothing to send, duplicates and timeout with nothing in flight
    queue_event(make_event(swcs_pkg::ACT_SEND, 16'd0));
    queue_event(make_event(ACT_UNUSED, 16'hFFFF));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd0));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd0));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd0));
    queue_event(make_event(swcs_pkg::ACT_TIMEOUT, 16'd0));
    wait_idle();

    write_reg(swcs_pkg::CFG_SLOW_START_LIMIT, 16'd255);
    write_reg(swcs_pkg::CFG_TOTAL_PACKETS, 16'd20);
    @(negedge clk);
    repeat (5) queue_event(make_event(swcs_pkg::ACT_SEND, 16'd0));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'hFFFF));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd0));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd1));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd3));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd3));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd3));
    queue_event(make_event(swcs_pkg::ACT_TIMEOUT, 16'h5A5A));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd4));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd5));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd5));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'd5));
    queue_event(make_event(swcs_pkg::ACT_SEND, 16'd0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_idling(p % 4);
      lim = (p == 0) ? 8'd255 : (p == 1) ? 8'd1 : 8'($urandom_range(255, 1));
      if (p == NUM_PHASES - 1) begin
        tot = 65535;
      end else if (p == 5) begin
        tot = 0;
      end else begin
        tot = gen_st.next_id - 1 + $urandom_range(150, 8);
        if (tot > 65535) begin
          tot = 65535;
        end
      end
      write_reg(swcs_pkg::CFG_SLOW_START_LIMIT, {8'd0, lim});
      write_reg(swcs_pkg::CFG_TOTAL_PACKETS, tot[15:0]);
      @(negedge clk);
      fill_random(95);
      wait_idle();
      fill_random(95);
    end

    // window halved down to nothing, then no more packets released
    repeat (9) queue_event(make_event(swcs_pkg::ACT_TIMEOUT, 16'($urandom)));
    repeat (3) queue_event(make_event(swcs_pkg::ACT_SEND, 16'($urandom)));
    queue_event(make_event(swcs_pkg::ACT_ACK, 16'($urandom)));
    wait_idle();

    $display("%0d events over %0d register settings, %0d packets checked (%0d resends)",
             events_taken, NUM_PHASES + 1, tx_seen, resends_seen);
    $display("final window %0d.%0d/256, %0d cycles", chk_st.cwnd[15:8], chk_st.cwnd[7:0], cycles);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/swcs_pkg.sv
src/swcs_engine.sv
src/sliding_window_congestion_sender.sv
test/tb_sliding_window_congestion_sender.sv
